### rtl/core/ibmf2i_pkg.sv
// Package for the IBM hex float to IEEE single converter.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ibmf2i_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 24;
  localparam int unsigned ExpoW = 7;
  localparam int unsigned MsbW  = 5;

  localparam logic [WordW-1:0] ByteOrderNegZero = 32'h0000_0080;
  localparam logic [WordW-1:0] NegZeroWord      = 32'h8000_0000;
  localparam logic [WordW-1:0] InfBits          = 32'h7F80_0000;

  // Decoded word, first pipeline stage contents.
  typedef struct packed {
    logic             sign;
    logic [ExpoW-1:0] expo;
    logic [FracW-1:0] frac;
    logic [MsbW-1:0]  msb;
    logic             special;
    logic [WordW-1:0] special_val;
  } dec_t;

endpackage
`default_nettype wire

### rtl/core/ibmf2i_if.sv
// Channel interfaces: input samples, output samples, configuration writes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ibmf2i_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_word;
  logic        end_of_trace;
  modport source (output valid, raw_word, end_of_trace, input ready);
  modport sink (input valid, raw_word, end_of_trace, output ready);
endinterface

interface ibmf2i_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ieee_word;
  logic        end_of_trace_out;
  modport source (output valid, ieee_word, end_of_trace_out, input ready);
  modport sink (input valid, ieee_word, end_of_trace_out, output ready);
endinterface

interface ibmf2i_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/core/ibm_float_to_ieee_single.sv
// Top level: IBM hex float to IEEE-754 single streaming converter.
// Depends on ibmf2i_pkg, ibmf2i_if, ibmf2i_decode.
`timescale 1ns / 1ps
`default_nettype none
// Converts one 32-bit IBM hexadecimal float sample per clock into an IEEE-754
// single (round to nearest even, overflow to infinity, gradual underflow),
// optionally byte-swapping first when the configured le_q flag is set. The
// pipeline stages are decode/leading-one search, exponent and shift, then
// the subnormal round-up add into the output register. Throughput is one
// beat per cycle; the whole pipeline holds while the output beat waits.
// end_of_trace travels alongside each sample.
module ibm_float_to_ieee_single (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ibmf2i_cfg_if.sink    cfg_i,
  ibmf2i_in_if.sink     in_i,
  ibmf2i_out_if.source  out_o
);
  import ibmf2i_pkg::*;

  logic le_q;
  logic adv;

  dec_t dec_d, dec_q;
  logic v1_q, eot1_q;
  logic v2_q, eot2_q, inc_q;
  logic [WordW-1:0] r_q, r_d;
  logic inc_d;
  logic v3_q, eot3_q;
  logic [WordW-1:0] out_q;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
    end else if (cfg_i.valid) begin
      le_q <= cfg_i.data;
    end
  end

  assign adv        = !v3_q || out_o.ready;
  assign in_i.ready = adv;

  ibmf2i_decode u_decode (
    .raw_i  (in_i.raw_word),
    .swap_i (le_q),
    .dec_o  (dec_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dec_q  <= dec_d;
      eot1_q <= in_i.end_of_trace;
      r_q    <= r_d;
      inc_q  <= inc_d;
      eot2_q <= eot1_q;
      out_q  <= r_q + WordW'(inc_q);
      eot3_q <= eot2_q;
    end
  end

  // Stage 2: exponent, normal mantissa shift, subnormal alignment.
  logic signed [9:0] biased;
  logic signed [9:0] k;
  logic [7:0]        s;
  logic [4:0]        s5;
  logic [FracW:0]    fx;
  logic [FracW:0]    mask;
  logic [FracW-1:0]  mant;
  logic [22:0]       kept;

  always_comb begin
    biased = $signed({5'b0, dec_q.msb}) + $signed({1'b0, dec_q.expo, 2'b0}) - 10'sd153;
    k      = $signed({1'b0, dec_q.expo, 2'b0}) - 10'sd131;
    s      = 8'(-k);
    s5     = s[4:0];
    fx     = {1'b0, dec_q.frac};
    mant   = dec_q.frac << (5'd23 - dec_q.msb);
    mask   = (25'd1 << (s5 - 5'd1)) - 25'd1;
    kept   = '0;
    inc_d  = 1'b0;
    r_d    = '0;
    if (dec_q.special) begin
      r_d = dec_q.special_val;
    end else if (biased >= 10'sd255) begin
      r_d = {dec_q.sign, 31'b0} | InfBits;
    end else if (biased >= 10'sd1) begin
      r_d = {dec_q.sign, biased[7:0], mant[22:0]};
    end else begin
      if (k >= 10'sd0) begin
        kept = 23'(dec_q.frac << k[4:0]);
      end else if (s < 8'd26) begin
        kept  = 23'(fx >> s5);
        inc_d = fx[s5 - 5'd1] && ((|(fx & mask)) || kept[0]);
      end
      r_d = {dec_q.sign, 8'b0, kept};
    end
  end

  assign out_o.valid            = v3_q;
  assign out_o.ieee_word        = out_q;
  assign out_o.end_of_trace_out = eot3_q;
endmodule
`default_nettype wire

### rtl/core/ibmf2i_decode.sv
// Byte swap and field decode with leading-one search.
// Depends on ibmf2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ibmf2i_decode (
  input  wire logic [31:0]      raw_i,
  input  wire logic             swap_i,
  output ibmf2i_pkg::dec_t      dec_o
);
  import ibmf2i_pkg::*;

  logic [WordW-1:0] w;
  logic [FracW-1:0] frac;
  logic [MsbW-1:0]  msb;

  assign w = swap_i ? {raw_i[7:0], raw_i[15:8], raw_i[23:16], raw_i[31:24]} : raw_i;
  assign frac = w[FracW-1:0];

  always_comb begin
    msb = '0;
    for (int i = 0; i < FracW; i++) begin
      if (frac[i]) msb = MsbW'(i);
    end
  end

  always_comb begin
    dec_o.sign        = w[31];
    dec_o.expo        = w[30:24];
    dec_o.frac        = frac;
    dec_o.msb         = msb;
    dec_o.special     = 1'b0;
    dec_o.special_val = '0;
    if (w == '0) begin
      dec_o.special = 1'b1;
    end else if (w == ByteOrderNegZero) begin
      dec_o.special     = 1'b1;
      dec_o.special_val = NegZeroWord;
    end else if (frac == '0) begin
      dec_o.special     = 1'b1;
      dec_o.special_val = {w[31], 31'b0};
    end
  end
endmodule
`default_nettype wire
